// ----- hw/rtl/iasel_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iasel_pkg
// shared types and constants of the interval activity selector
// ----------------------------------------------------------------------------
package iasel_pkg;

    localparam int MAX_EVENTS_DEF = 64;
    localparam int TIME_WIDTH_DEF = 16;

    // fixed payload widths
    localparam int IN_TIME_W = 16;
    localparam int OUT_NUM_W = 7;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DONE
    } t_state;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;    // sorted insertion of the broadcast interval
        logic shift;  // chain moves one place towards the head
    } t_cell_ctl;

endpackage

// ----- hw/rtl/iasel_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iasel_in_if / iasel_out_if
// valid/ready channels of the interval activity selector
// ----------------------------------------------------------------------------
interface iasel_in_if import iasel_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [IN_TIME_W-1:0] start_time;
    logic [IN_TIME_W-1:0] end_time;
    logic                 last_item;

    modport source (output valid, output start_time, output end_time, output last_item,
                    input ready);
    modport sink   (input valid, input start_time, input end_time, input last_item,
                    output ready);
endinterface

interface iasel_out_if import iasel_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [OUT_NUM_W-1:0] event_number;
    logic [IN_TIME_W-1:0] kept_start;
    logic [IN_TIME_W-1:0] kept_end;
    logic [OUT_NUM_W-1:0] kept_total;
    logic                 overflow;
    logic                 last_result;

    modport source (output valid, output event_number, output kept_start, output kept_end,
                    output kept_total, output overflow, output last_result,
                    input ready);
    modport sink   (input valid, input event_number, input kept_start, input kept_end,
                    input kept_total, input overflow, input last_result,
                    output ready);
endinterface

// ----- hw/rtl/iasel_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iasel_cell
// one slot of the end-time ordered chain: holds one interval, makes room for
// an insertion by passing its entry up, and passes entries down while scanning
// ----------------------------------------------------------------------------
module iasel_cell import iasel_pkg::*; #(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF,
    parameter int NUM_W      = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [TIME_WIDTH-1:0] i_new_start,
    input  logic [TIME_WIDTH-1:0] i_new_end,
    input  logic [NUM_W-1:0]      i_new_num,
    input  logic                  i_prev_valid,
    input  logic                  i_prev_gt,
    input  logic [TIME_WIDTH-1:0] i_prev_start,
    input  logic [TIME_WIDTH-1:0] i_prev_end,
    input  logic [NUM_W-1:0]      i_prev_num,
    input  logic                  i_next_valid,
    input  logic [TIME_WIDTH-1:0] i_next_start,
    input  logic [TIME_WIDTH-1:0] i_next_end,
    input  logic [NUM_W-1:0]      i_next_num,
    output logic                  o_valid,
    output logic                  o_gt,
    output logic [TIME_WIDTH-1:0] o_start,
    output logic [TIME_WIDTH-1:0] o_end,
    output logic [NUM_W-1:0]      o_num
);

    logic                  r_valid;
    logic [TIME_WIDTH-1:0] r_start;
    logic [TIME_WIDTH-1:0] r_end;
    logic [NUM_W-1:0]      r_num;

    logic                  n_valid;
    logic [TIME_WIDTH-1:0] n_start;
    logic [TIME_WIDTH-1:0] n_end;
    logic [NUM_W-1:0]      n_num;
    logic                  gt;

    // strictly greater keeps equal end times in arrival order
    assign gt = r_valid && (r_end > i_new_end);

    always_comb begin
        n_valid = r_valid;
        n_start = r_start;
        n_end   = r_end;
        n_num   = r_num;
        if (i_ctl.shift) begin
            n_valid = i_next_valid;
            n_start = i_next_start;
            n_end   = i_next_end;
            n_num   = i_next_num;
        end else if (i_ctl.ins) begin
            if (i_prev_gt) begin
                n_valid = 1'b1;
                n_start = i_prev_start;
                n_end   = i_prev_end;
                n_num   = i_prev_num;
            end else if (i_prev_valid && (gt || !r_valid)) begin
                // insertion point: first slot past all entries with end <= new end
                n_valid = 1'b1;
                n_start = i_new_start;
                n_end   = i_new_end;
                n_num   = i_new_num;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_end   <= n_end;
        r_num   <= n_num;
    end

    assign o_valid = r_valid;
    assign o_gt    = gt;
    assign o_start = r_start;
    assign o_end   = r_end;
    assign o_num   = r_num;

endmodule

// ----- hw/rtl/interval_activity_selector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_activity_selector
// greedy activity selection by earliest finish over a sorted chain of cells
// ----------------------------------------------------------------------------
//  channel | dir | handshake      | payload
//  i_in    | in  | valid / ready  | start_time, end_time, last_item
//  o_out   | out | valid / ready  | event_number, kept_start, kept_end,
//          |     |                | kept_total, overflow, last_result
//
//  loading inserts each interval in order of end time into the cell chain in
//  a single broadcast step; items beyond MAX_EVENTS are dropped and set overflow.
//  after the item marked last, the scan shifts the chain to its head one cell
//  a cycle unless a stalled o_out holds it; the final result is registered
//  once the scan is through and o_out is free.
//  i_in.ready is low from the last item until the final result is registered.
//  synchronous active-low reset empties the chain and the output register.
// ----------------------------------------------------------------------------
module interval_activity_selector import iasel_pkg::*; #(
    parameter int MAX_EVENTS = MAX_EVENTS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    iasel_in_if.sink     i_in,
    iasel_out_if.source  o_out
);

    localparam int CNT_W = $clog2(MAX_EVENTS + 1);

    t_state                r_state,   n_state;
    logic [CNT_W-1:0]      r_loaded,  n_loaded;
    logic                  r_dropped, n_dropped;
    logic [CNT_W-1:0]      r_scan,    n_scan;
    logic [CNT_W-1:0]      r_kcnt,    n_kcnt;
    logic                  r_p_valid, n_p_valid;
    logic [TIME_WIDTH-1:0] r_p_start, n_p_start;
    logic [TIME_WIDTH-1:0] r_p_end,   n_p_end;
    logic [CNT_W-1:0]      r_p_num,   n_p_num;

    logic                  r_out_valid;
    logic [OUT_NUM_W-1:0]  r_out_num;
    logic [IN_TIME_W-1:0]  r_out_start;
    logic [IN_TIME_W-1:0]  r_out_end;
    logic [OUT_NUM_W-1:0]  r_out_total;
    logic                  r_out_ovf;
    logic                  r_out_last;

    t_cell_ctl             ctl;
    logic                  emit;
    logic                  emit_last;
    logic                  out_free;
    logic                  full;
    logic                  kept;
    logic [TIME_WIDTH-1:0] new_start;
    logic [TIME_WIDTH-1:0] new_end;
    logic [CNT_W-1:0]      new_num;
    logic [31:0]           in_start32;
    logic [31:0]           in_end32;
    logic [31:0]           p_start32;
    logic [31:0]           p_end32;
    logic [31:0]           p_num32;
    logic [31:0]           kcnt32;

    logic                  c_valid [MAX_EVENTS];
    logic                  c_gt    [MAX_EVENTS];
    logic [TIME_WIDTH-1:0] c_start [MAX_EVENTS];
    logic [TIME_WIDTH-1:0] c_end   [MAX_EVENTS];
    logic [CNT_W-1:0]      c_num   [MAX_EVENTS];

    // times beyond TIME_WIDTH are ignored
    assign in_start32 = 32'(i_in.start_time);
    assign in_end32   = 32'(i_in.end_time);
    assign new_start  = in_start32[TIME_WIDTH-1:0];
    assign new_end    = in_end32[TIME_WIDTH-1:0];
    assign new_num    = r_loaded + CNT_W'(1);

    assign full     = (r_loaded == CNT_W'(MAX_EVENTS));
    assign out_free = !r_out_valid || o_out.ready;
    assign kept     = !r_p_valid || (c_start[0] >= r_p_end);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_EVENTS; gi++) begin : g_cell
            logic                  prev_valid;
            logic                  prev_gt;
            logic [TIME_WIDTH-1:0] prev_start;
            logic [TIME_WIDTH-1:0] prev_end;
            logic [CNT_W-1:0]      prev_num;
            logic                  next_valid;
            logic [TIME_WIDTH-1:0] next_start;
            logic [TIME_WIDTH-1:0] next_end;
            logic [CNT_W-1:0]      next_num;

            if (gi == 0) begin : g_head
                // head boundary: always allows insertion, never passes an entry up
                assign prev_valid = 1'b1;
                assign prev_gt    = 1'b0;
                assign prev_start = '0;
                assign prev_end   = '0;
                assign prev_num   = '0;
            end else begin : g_mid
                assign prev_valid = c_valid[gi-1];
                assign prev_gt    = c_gt[gi-1];
                assign prev_start = c_start[gi-1];
                assign prev_end   = c_end[gi-1];
                assign prev_num   = c_num[gi-1];
            end

            if (gi == MAX_EVENTS - 1) begin : g_tail
                assign next_valid = 1'b0;
                assign next_start = '0;
                assign next_end   = '0;
                assign next_num   = '0;
            end else begin : g_body
                assign next_valid = c_valid[gi+1];
                assign next_start = c_start[gi+1];
                assign next_end   = c_end[gi+1];
                assign next_num   = c_num[gi+1];
            end

            iasel_cell #(
                .TIME_WIDTH (TIME_WIDTH),
                .NUM_W      (CNT_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (ctl),
                .i_new_start  (new_start),
                .i_new_end    (new_end),
                .i_new_num    (new_num),
                .i_prev_valid (prev_valid),
                .i_prev_gt    (prev_gt),
                .i_prev_start (prev_start),
                .i_prev_end   (prev_end),
                .i_prev_num   (prev_num),
                .i_next_valid (next_valid),
                .i_next_start (next_start),
                .i_next_end   (next_end),
                .i_next_num   (next_num),
                .o_valid      (c_valid[gi]),
                .o_gt         (c_gt[gi]),
                .o_start      (c_start[gi]),
                .o_end        (c_end[gi]),
                .o_num        (c_num[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state   = r_state;
        n_loaded  = r_loaded;
        n_dropped = r_dropped;
        n_scan    = r_scan;
        n_kcnt    = r_kcnt;
        n_p_valid = r_p_valid;
        n_p_start = r_p_start;
        n_p_end   = r_p_end;
        n_p_num   = r_p_num;
        ctl       = '0;
        emit      = 1'b0;
        emit_last = 1'b0;
        case (r_state)
            ST_LOAD: begin
                if (i_in.valid) begin
                    if (!full) begin
                        ctl.ins  = 1'b1;
                        n_loaded = new_num;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_in.last_item) begin
                        n_state   = ST_SCAN;
                        n_scan    = '0;
                        n_kcnt    = '0;
                        n_p_valid = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                if (r_scan == r_loaded) begin
                    n_state = ST_DONE;
                end else if (!kept || !r_p_valid || out_free) begin
                    // head cell is examined, then the chain moves down by one
                    ctl.shift = 1'b1;
                    n_scan    = r_scan + CNT_W'(1);
                    if (kept) begin
                        // previous kept interval is now known not to be the last
                        emit      = r_p_valid;
                        n_p_valid = 1'b1;
                        n_p_start = c_start[0];
                        n_p_end   = c_end[0];
                        n_p_num   = c_num[0];
                        n_kcnt    = r_kcnt + CNT_W'(1);
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    n_state   = ST_LOAD;
                    n_loaded  = '0;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_loaded    <= '0;
            r_dropped   <= 1'b0;
            r_scan      <= '0;
            r_kcnt      <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_loaded  <= n_loaded;
            r_dropped <= n_dropped;
            r_scan    <= n_scan;
            r_kcnt    <= n_kcnt;
            r_p_valid <= n_p_valid;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign p_start32 = 32'(r_p_start);
    assign p_end32   = 32'(r_p_end);
    assign p_num32   = 32'(r_p_num);
    assign kcnt32    = 32'(r_kcnt);

    always_ff @(posedge i_clk) begin
        r_p_start <= n_p_start;
        r_p_end   <= n_p_end;
        r_p_num   <= n_p_num;
        if (emit) begin
            r_out_num   <= p_num32[OUT_NUM_W-1:0];
            r_out_start <= p_start32[IN_TIME_W-1:0];
            r_out_end   <= p_end32[IN_TIME_W-1:0];
            r_out_total <= emit_last ? kcnt32[OUT_NUM_W-1:0] : '0;
            r_out_ovf   <= r_dropped;
            r_out_last  <= emit_last;
        end
    end

    assign i_in.ready         = (r_state == ST_LOAD);
    assign o_out.valid        = r_out_valid;
    assign o_out.event_number = r_out_num;
    assign o_out.kept_start   = r_out_start;
    assign o_out.kept_end     = r_out_end;
    assign o_out.kept_total   = r_out_total;
    assign o_out.overflow     = r_out_ovf;
    assign o_out.last_result  = r_out_last;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the interval activity selector: intervals are
// driven in sets over the input channel, a local greedy scheduler predicts the
// kept intervals of every set, and each result is checked field by field
// under phases of random idling, a long output hold-off and drained pauses
// ----------------------------------------------------------------------------
module tb_top;
    import iasel_pkg::*;

    localparam int CAPACITY    = MAX_EVENTS_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = CAPACITY + 16;

    typedef struct packed {
        logic [IN_TIME_W-1:0] start_t;
        logic [IN_TIME_W-1:0] end_t;
        logic                 last;
    } t_interval;

    typedef struct packed {
        logic [OUT_NUM_W-1:0] number;
        logic [IN_TIME_W-1:0] k_start;
        logic [IN_TIME_W-1:0] k_end;
        logic [OUT_NUM_W-1:0] total;
        logic                 ovf;
        logic                 fin;
    } t_kept;

    logic i_clk;
    logic i_rst_n;

    iasel_in_if  in_ch ();
    iasel_out_if out_ch ();

    interval_activity_selector u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // intervals waiting to be offered, and kept intervals still to arrive
    t_interval pending_q[$];
    t_kept     kept_q[$];

    // local copy of the end-ordered chain
    logic [IN_TIME_W-1:0] held_start [CAPACITY];
    logic [IN_TIME_W-1:0] held_end   [CAPACITY];
    logic [OUT_NUM_W-1:0] held_num   [CAPACITY];
    int                   held_cnt;
    bit                   held_dropped;

    int n_sent;
    int n_accepted;
    int mismatch_cnt;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_asks;
    int hold_served;
    int hold_left;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    // sorted insertion and, on the last item, greedy earliest-finish scan
    task automatic schedule_interval(input t_interval it);
        int pos;
        int idx;
        int picks[$];
        logic [IN_TIME_W-1:0] fence;
        t_kept r;
        if (held_cnt < CAPACITY) begin
            pos = held_cnt;
            // equal end times stay in arrival order
            while (pos > 0 && held_end[pos-1] > it.end_t) begin
                held_start[pos] = held_start[pos-1];
                held_end[pos]   = held_end[pos-1];
                held_num[pos]   = held_num[pos-1];
                pos--;
            end
            held_start[pos] = it.start_t;
            held_end[pos]   = it.end_t;
            held_num[pos]   = OUT_NUM_W'(held_cnt + 1);
            held_cnt++;
        end else begin
            held_dropped = 1'b1;
        end
        if (it.last) begin
            picks.delete();
            fence = held_end[0];
            for (idx = 0; idx < held_cnt; idx++) begin
                if (idx == 0 || held_start[idx] >= fence) begin
                    picks = {picks, idx};
                    fence = held_end[idx];
                end
            end
            for (idx = 0; idx < picks.size(); idx++) begin
                r.number  = held_num[picks[idx]];
                r.k_start = held_start[picks[idx]];
                r.k_end   = held_end[picks[idx]];
                r.ovf     = held_dropped;
                r.fin     = (idx == picks.size() - 1);
                r.total   = r.fin ? OUT_NUM_W'(picks.size()) : '0;
                kept_q = {kept_q, r};
            end
            held_cnt     = 0;
            held_dropped = 1'b0;
        end
    endtask

    task automatic push_interval(input int s, input int e, input bit last);
        t_interval it;
        it.start_t = IN_TIME_W'(s);
        it.end_t   = IN_TIME_W'(e);
        it.last    = last;
        pending_q = {pending_q, it};
    endtask

    // a set of n intervals, mostly clustered so that many overlap or chain
    task automatic queue_set(input int n);
        int i;
        int base;
        int s;
        int e;
        base = $urandom_range(0, 65535 - 400);
        for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: begin
                    s = $urandom_range(0, 65535);
                    e = $urandom_range(0, 65535);
                end
                1: begin
                    s = $urandom_range(0, 65535);
                    e = $urandom_range(0, s);
                end
                2: begin
                    s = $urandom_range(0, 1) ? 65535 : 0;
                    e = $urandom_range(0, 1) ? 65535 : 0;
                end
                default: begin
                    s = base + $urandom_range(0, 200);
                    e = s + $urandom_range(0, 40);
                end
            endcase
            push_interval(s, e, i == n - 1);
        end
    endtask

    task automatic wait_all_done();
        while (pending_q.size() != 0 || n_sent != n_accepted || kept_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // input driver
    initial begin
        in_ch.valid      = 1'b0;
        in_ch.start_time = '0;
        in_ch.end_time   = '0;
        in_ch.last_item  = 1'b0;
    end

    always @(negedge i_clk) begin
        t_interval it;
        if (in_ch.valid && n_accepted != n_sent) begin
            // item still on offer
        end else if (i_rst_n && pending_q.size() != 0
                     && $urandom_range(0, 99) >= send_idle_pct) begin
            it = pending_q.pop_front();
            in_ch.start_time <= it.start_t;
            in_ch.end_time   <= it.end_t;
            in_ch.last_item  <= it.last;
            in_ch.valid      <= 1'b1;
            n_sent++;
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // output ready, with the long hold-off counted here
    initial begin
        out_ch.ready = 1'b0;
    end

    always @(negedge i_clk) begin
        if (hold_served != hold_asks) begin
            hold_served = hold_asks;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // input monitor feeding the scheduler, and output checker
    always @(posedge i_clk) begin
        t_interval it;
        t_kept     want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                it.start_t = in_ch.start_time;
                it.end_t   = in_ch.end_time;
                it.last    = in_ch.last_item;
                schedule_interval(it);
                n_accepted++;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (kept_q.size() == 0) begin
                    report_mismatch("unexpected result, event_number", out_ch.event_number, 0);
                end else begin
                    want = kept_q.pop_front();
                    if (out_ch.event_number !== want.number)
                        report_mismatch("event_number", out_ch.event_number, want.number);
                    if (out_ch.kept_start !== want.k_start)
                        report_mismatch("kept_start", out_ch.kept_start, want.k_start);
                    if (out_ch.kept_end !== want.k_end)
                        report_mismatch("kept_end", out_ch.kept_end, want.k_end);
                    if (out_ch.kept_total !== want.total)
                        report_mismatch("kept_total", out_ch.kept_total, want.total);
                    if (out_ch.overflow !== want.ovf)
                        report_mismatch("overflow", out_ch.overflow, want.ovf);
                    if (out_ch.last_result !== want.fin)
                        report_mismatch("last_result", out_ch.last_result, want.fin);
                end
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        int phase_items;
        int n;
        n_sent         = 0;
        n_accepted     = 0;
        mismatch_cnt   = 0;
        held_cnt       = 0;
        held_dropped   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asks      = 0;
        hold_served    = 0;
        hold_left      = 0;
        quiet_cycles   = 0;

        // single intervals at the extremes
        push_interval(0, 0, 1'b1);
        push_interval(65535, 65535, 1'b1);
        // equal end times, touching intervals, start after end
        push_interval(5, 10, 1'b0);
        push_interval(3, 10, 1'b0);
        push_interval(0, 10, 1'b0);
        push_interval(10, 20, 1'b0);
        push_interval(20, 20, 1'b0);
        push_interval(19, 25, 1'b0);
        push_interval(40000, 100, 1'b1);
        // one long interval arriving first, short ones chained after it
        push_interval(0, 65535, 1'b0);
        push_interval(1, 2, 1'b0);
        push_interval(2, 3, 1'b0);
        push_interval(3, 4, 1'b1);
        // alternating bit patterns
        push_interval(16'hAAAA, 16'h5555, 1'b0);
        push_interval(16'h5555, 16'hAAAA, 1'b1);
        wait_all_done();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            phase_items = 0;
            if (phase == 0) begin
                // output held off while an overflowing set and more sets are offered
                hold_asks++;
                queue_set(CAPACITY + 2);
                queue_set(3);
                queue_set(2);
                phase_items = CAPACITY + 7;
            end else if (phase == 2) begin
                queue_set(CAPACITY);
                queue_set(CAPACITY + 1);
                phase_items = 2 * CAPACITY + 1;
            end
            while (phase_items < 80) begin
                n = ($urandom_range(0, 11) == 0) ? $urandom_range(CAPACITY - 4, CAPACITY + 6)
                                                 : $urandom_range(1, 10);
                queue_set(n);
                phase_items += n;
            end
            // sender pauses until every kept interval has come out
            wait_all_done();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
